/* hdl/ale_pkg.sv */
// ----------------------------------------------------------------------------
// ale_pkg
// Shared widths, operation codes and status codes of the array list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ale_pkg;

    localparam int WORD_W   = 32;
    localparam int FUNC_W   = 4;
    localparam int POS_W    = 7;
    localparam int HIT_W    = 6;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_APPEND  = 4'd0;
    localparam logic [FUNC_W-1:0] FN_INSERT  = 4'd1;
    localparam logic [FUNC_W-1:0] FN_DELETE  = 4'd2;
    localparam logic [FUNC_W-1:0] FN_GET     = 4'd3;
    localparam logic [FUNC_W-1:0] FN_SET     = 4'd4;
    localparam logic [FUNC_W-1:0] FN_SEARCH  = 4'd5;
    localparam logic [FUNC_W-1:0] FN_SHL     = 4'd6;
    localparam logic [FUNC_W-1:0] FN_SHR     = 4'd7;
    localparam logic [FUNC_W-1:0] FN_ROTL    = 4'd8;
    localparam logic [FUNC_W-1:0] FN_ROTR    = 4'd9;
    localparam logic [FUNC_W-1:0] FN_REVERSE = 4'd10;
    localparam logic [FUNC_W-1:0] FN_MAXMIN  = 4'd11;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BADIDX   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

endpackage

`default_nettype wire

/* hdl/ale_if.sv */
// ----------------------------------------------------------------------------
// ale_if
// Valid/ready channels of the array list engine: command and result.
// ----------------------------------------------------------------------------
`default_nettype none

interface ale_cmd_if import ale_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] value;

    modport source (output valid, func, position, value, input ready);
    modport sink   (input valid, func, position, value, output ready);
endinterface

interface ale_res_if import ale_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [WORD_W-1:0] data;
    logic signed [WORD_W-1:0] data_min;
    logic [HIT_W-1:0]         hit_index;
    logic [STATUS_W-1:0]      status;
    logic [COUNT_W-1:0]       count;

    modport source (output valid, data, data_min, hit_index, status, count, input ready);
    modport sink   (input valid, data, data_min, hit_index, status, count, output ready);
endinterface

`default_nettype wire

/* hdl/ale_cell.sv */
// ----------------------------------------------------------------------------
// ale_cell
// One list slot. While the ring advances, a slot below the tail takes the
// word of its upper neighbor and the tail slot takes the feed word.
// ----------------------------------------------------------------------------
`default_nettype none

module ale_cell import ale_pkg::*; #(
    parameter int IW    = 6,
    parameter int INDEX = 0
) (
    input  wire logic              clk,
    input  wire logic              advance,
    input  wire logic [IW-1:0]     tail,
    input  wire logic [WORD_W-1:0] right_word,
    input  wire logic [WORD_W-1:0] feed,
    output logic      [WORD_W-1:0] word
);

    localparam logic [IW-1:0] MY_INDEX = IW'(INDEX);

    logic [WORD_W-1:0] word_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (MY_INDEX < tail)
                word_reg <= right_word;
            else if (MY_INDEX == tail)
                word_reg <= feed;
        end
    end

    assign word = word_reg;

endmodule

`default_nettype wire

/* hdl/ale_ctrl.sv */
// ----------------------------------------------------------------------------
// ale_ctrl
// Head of the ring: decodes a command, runs one pass of the ring under the
// head slot, builds the feed word and collects the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ale_ctrl import ale_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    ale_cmd_if.sink                cmd,
    ale_res_if.source              res,
    input  wire logic [WORD_W-1:0] head_word,
    input  wire logic [WORD_W-1:0] next_word,
    output logic                   advance,
    output logic [$clog2(CAPACITY)-1:0] tail,
    output logic [WORD_W-1:0]      feed
);

    localparam int IW = $clog2(CAPACITY);
    localparam int UW = $clog2(CAPACITY + 1);
    localparam int CW = (UW > POS_W) ? UW : POS_W;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_FIN  = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [UW-1:0]      used_reg, used_next;
    logic               res_valid_reg;

    logic [FUNC_W-1:0]   op_reg;
    logic [CW-1:0]       pos_reg;
    logic [WORD_W-1:0]   val_reg;
    logic [IW-1:0]       k_reg;
    logic [IW-1:0]       last_reg;
    logic [IW-1:0]       tail_reg;
    logic [WORD_W-1:0]   prev_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [WORD_W-1:0]   data_reg;
    logic [WORD_W-1:0]   dmin_reg;
    logic [IW-1:0]       hit_reg;
    logic                found_reg;

    logic [WORD_W-1:0]   res_data_reg;
    logic [WORD_W-1:0]   res_dmin_reg;
    logic [HIT_W-1:0]    res_hit_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [COUNT_W-1:0]  res_count_reg;

    logic                accept;
    logic                run_last;
    logic                fin_load;

    // command decode
    logic [STATUS_W-1:0] dec_status;
    logic                dec_go;
    logic [UW-1:0]       dec_len;
    logic [UW-1:0]       dec_steps;
    logic [CW-1:0]       cmd_pos_x;
    logic [CW-1:0]       used_x;
    logic                is_full;
    logic                is_empty;

    // step decode
    logic [CW-1:0]       k_x;
    logic                at_pos;
    logic                below_pos;

    assign accept   = cmd.valid && cmd.ready;
    assign run_last = (state_reg == S_RUN) && (k_reg == last_reg);
    assign fin_load = (state_reg == S_FIN) && (!res_valid_reg || res.ready);

    assign cmd_pos_x = CW'(cmd.position);
    assign used_x    = CW'(used_reg);
    assign is_full   = (used_reg == UW'(CAPACITY));
    assign is_empty  = (used_reg == '0);

    always_comb
    begin
        dec_status = ST_OK;
        dec_go     = 1'b0;
        dec_len    = used_reg;
        dec_steps  = used_reg;
        used_next  = used_reg;
        case (cmd.func)
            FN_APPEND, FN_INSERT:
            begin
                if ((cmd.func == FN_INSERT) && (cmd_pos_x > used_x))
                    dec_status = ST_BADIDX;
                else if (is_full)
                    dec_status = ST_FULL;
                else
                begin
                    dec_go    = 1'b1;
                    dec_len   = used_reg + UW'(1);
                    dec_steps = used_reg + UW'(1);
                    used_next = used_reg + UW'(1);
                end
            end
            FN_DELETE, FN_GET, FN_SET:
            begin
                if (is_empty)
                    dec_status = ST_EMPTY;
                else if (cmd_pos_x >= used_x)
                    dec_status = ST_BADIDX;
                else
                begin
                    dec_go = 1'b1;
                    if (cmd.func == FN_DELETE)
                        used_next = used_reg - UW'(1);
                end
            end
            FN_SEARCH, FN_SHR, FN_REVERSE, FN_MAXMIN:
            begin
                if (is_empty)
                    dec_status = ST_EMPTY;
                else
                begin
                    dec_go = 1'b1;
                    // search starts as a miss and is cleared on the first hit
                    if (cmd.func == FN_SEARCH)
                        dec_status = ST_NOTFOUND;
                end
            end
            FN_SHL, FN_ROTL:
            begin
                if (is_empty)
                    dec_status = ST_EMPTY;
                else
                begin
                    dec_go    = 1'b1;
                    dec_steps = UW'(1);
                end
            end
            FN_ROTR:
            begin
                // rotating left by length-1 is a right rotate by one
                if (is_empty)
                    dec_status = ST_EMPTY;
                else
                begin
                    dec_steps = used_reg - UW'(1);
                    dec_go    = (dec_steps != '0);
                end
            end
            default:
            begin
                dec_status = ST_OK;
            end
        endcase
    end

    assign k_x       = CW'(k_reg);
    assign at_pos    = (k_x == pos_reg);
    assign below_pos = (k_x < pos_reg);

    always_comb
    begin
        case (op_reg)
            FN_APPEND: feed = (k_reg == last_reg) ? val_reg : head_word;
            FN_INSERT: feed = below_pos ? head_word : (at_pos ? val_reg : prev_reg);
            FN_DELETE: feed = below_pos ? head_word : next_word;
            FN_SET:    feed = at_pos ? val_reg : head_word;
            FN_SHL:    feed = '0;
            FN_SHR:    feed = (k_reg == '0) ? '0 : prev_reg;
            default:   feed = head_word;
        endcase
    end

    assign advance = (state_reg == S_RUN);
    assign tail    = tail_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = dec_go ? S_RUN : S_FIN;
            end
            S_RUN:
            begin
                if (run_last)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (fin_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
                used_reg <= used_next;
            if (fin_load)
                res_valid_reg <= 1'b1;
            else if (res.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= cmd.func;
            pos_reg    <= cmd_pos_x;
            val_reg    <= cmd.value;
            k_reg      <= '0;
            last_reg   <= IW'(dec_steps - UW'(1));
            tail_reg   <= IW'(dec_len - UW'(1));
            status_reg <= dec_status;
            data_reg   <= '0;
            dmin_reg   <= '0;
            hit_reg    <= '0;
            found_reg  <= 1'b0;
        end
        else if (state_reg == S_RUN)
        begin
            k_reg    <= k_reg + IW'(1);
            prev_reg <= head_word;
            // reverse: the tail slot walks down, dropping each head below it
            if (op_reg == FN_REVERSE)
                tail_reg <= tail_reg - IW'(1);
            case (op_reg)
                FN_GET:
                begin
                    if (at_pos)
                        data_reg <= head_word;
                end
                FN_SEARCH:
                begin
                    if (!found_reg && (head_word == val_reg))
                    begin
                        found_reg  <= 1'b1;
                        hit_reg    <= k_reg;
                        status_reg <= ST_OK;
                    end
                end
                FN_MAXMIN:
                begin
                    if (k_reg == '0)
                    begin
                        data_reg <= head_word;
                        dmin_reg <= head_word;
                    end
                    else
                    begin
                        if ($signed(head_word) > $signed(data_reg))
                            data_reg <= head_word;
                        if ($signed(head_word) < $signed(dmin_reg))
                            dmin_reg <= head_word;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (fin_load)
        begin
            res_data_reg   <= data_reg;
            res_dmin_reg   <= dmin_reg;
            res_hit_reg    <= HIT_W'(hit_reg);
            res_status_reg <= status_reg;
            res_count_reg  <= COUNT_W'(used_reg);
        end
    end

    assign cmd.ready     = (state_reg == S_IDLE);
    assign res.valid     = res_valid_reg;
    assign res.data      = res_data_reg;
    assign res.data_min  = res_dmin_reg;
    assign res.hit_index = res_hit_reg;
    assign res.status    = res_status_reg;
    assign res.count     = res_count_reg;

endmodule

`default_nettype wire

/* hdl/array_list_engine.sv */
// Sequence: an accepted command runs a ring pass of m steps, then the result is
//   registered and res.valid raised; m = 1 for shift/rotate left, length-1 for
//   rotate right, the length (plus one for append/insert) otherwise, 0 for rejected commands.
// A new command is taken only after the result of the last one is loaded; the word
//   ring moves one slot per cycle under the head unit during a pass.
// Reset: clears the length, the sequencer and the result valid; words are not cleared.
// ----------------------------------------------------------------------------
// array_list_engine
// Packed list of signed words kept in a ring of cells; one command a time.
// ----------------------------------------------------------------------------
`default_nettype none

module array_list_engine import ale_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ale_cmd_if.sink   cmd,
    ale_res_if.source res
);

    localparam int IW = $clog2(CAPACITY);

    logic [WORD_W-1:0] cell_word [CAPACITY];
    logic              advance;
    logic [IW-1:0]     tail;
    logic [WORD_W-1:0] feed;

    ale_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .res       (res),
        .head_word (cell_word[0]),
        .next_word (cell_word[1]),
        .advance   (advance),
        .tail      (tail),
        .feed      (feed)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam int RIGHT = (i + 1 < CAPACITY) ? i + 1 : 0;

        ale_cell #(
            .IW    (IW),
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .advance    (advance),
            .tail       (tail),
            .right_word (cell_word[RIGHT]),
            .feed       (feed),
            .word       (cell_word[i])
        );
    end

endmodule

`default_nettype wire

/* hdl/ale_checker.sv */
// ----------------------------------------------------------------------------
// ale_checker
// Port-level checks of the array list engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ale_checker import ale_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                cmd_valid,
    input wire logic                cmd_ready,
    input wire logic                res_valid,
    input wire logic                res_ready,
    input wire logic [WORD_W-1:0]   res_data,
    input wire logic [WORD_W-1:0]   res_data_min,
    input wire logic [HIT_W-1:0]    res_hit_index,
    input wire logic [STATUS_W-1:0] res_status,
    input wire logic [COUNT_W-1:0]  res_count
);

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data)
            && $stable(res_data_min) && $stable(res_hit_index)
            && $stable(res_status) && $stable(res_count))
        else $error("result changed while stalled");

    // one command in flight at a time
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while busy");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_status == ST_EMPTY) |-> (res_count == '0))
        else $error("empty status with nonzero count");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (res_status != ST_OK) |->
            (res_data == '0) && (res_data_min == '0) && (res_hit_index == '0))
        else $error("failed transaction carries data");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (CAPACITY > 127) || (res_count <= COUNT_W'(CAPACITY)))
        else $error("count above capacity");

endmodule

bind array_list_engine ale_checker #(
    .CAPACITY (CAPACITY)
) u_ale_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd.valid),
    .cmd_ready     (cmd.ready),
    .res_valid     (res.valid),
    .res_ready     (res.ready),
    .res_data      (res.data),
    .res_data_min  (res.data_min),
    .res_hit_index (res.hit_index),
    .res_status    (res.status),
    .res_count     (res.count)
);

`default_nettype wire
